// ===== design/mvt_pkg.sv =====
// Shared types and constants of the matrix-vector transform unit.
package mvt_pkg;

   localparam int COMP_W     = 32;
   localparam int PROD_W     = 2 * COMP_W;
   localparam int VEC_N      = 4;
   localparam int OP_W       = 2;
   localparam int IDX_W      = 2;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = VEC_N * COMP_W;

   localparam logic [COMP_W-1:0] SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic [COMP_W-1:0] SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_VECTOR = 2'd1,
      OP_POINT  = 2'd2
   } op_type;

   // Load strobes of the four datapath stages behind the input register.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } row_ctrl_type;

endpackage

// ===== design/mvt_row_dot.sv =====
// Pipelined dot product of one matrix row with rounding and saturation.
module mvt_row_dot #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  mvt_pkg::row_ctrl_type               ctrl,
   input  logic signed [mvt_pkg::COMP_W-1:0]   coeff [mvt_pkg::VEC_N],
   input  logic signed [mvt_pkg::COMP_W-1:0]   vec   [mvt_pkg::VEC_N],
   output logic        [mvt_pkg::COMP_W-1:0]   res,
   output logic                                sat
);
   import mvt_pkg::*;

   localparam int SUM2_W  = PROD_W + 1;
   localparam int SUM_W   = PROD_W + 2;
   localparam int SHIFT_W = SUM_W - FRACTION_BITS;
   localparam logic signed [SUM_W-1:0] HALF =
      {{(SUM_W-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);

   logic signed [PROD_W-1:0] prod_in [VEC_N];
   logic signed [PROD_W-1:0] prod_ff [VEC_N];
   logic signed [SUM2_W-1:0] pair_in [2];
   logic signed [SUM2_W-1:0] pair_ff [2];
   logic signed [SUM_W-1:0]  total_in;
   logic signed [SUM_W-1:0]  total_ff;
   logic        [SHIFT_W-1:0] shifted;
   logic        [SHIFT_W-COMP_W:0] upper;
   logic                     over;
   logic        [COMP_W-1:0] res_in;
   logic        [COMP_W-1:0] res_ff;
   logic                     sat_ff;

   always_comb begin
      for (int k = 0; k < VEC_N; k++) begin
         prod_in[k] = PROD_W'(coeff[k]) * PROD_W'(vec[k]);
      end
      pair_in[0] = SUM2_W'(prod_ff[0]) + SUM2_W'(prod_ff[1]);
      pair_in[1] = SUM2_W'(prod_ff[2]) + SUM2_W'(prod_ff[3]);
      total_in   = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]) + HALF;
   end

   // Shifted sum is in range when the result's sign bit and all bits above it agree.
   always_comb begin
      shifted = total_ff[SUM_W-1:FRACTION_BITS];
      upper   = shifted[SHIFT_W-1:COMP_W-1];
      over    = !(&upper) && (|upper);
      if (over) begin
         res_in = shifted[SHIFT_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         res_in = shifted[COMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld1) begin
         prod_ff <= prod_in;
      end
      if (ctrl.ld2) begin
         pair_ff <= pair_in;
      end
      if (ctrl.ld3) begin
         total_ff <= total_in;
      end
      if (ctrl.ld4) begin
         res_ff <= res_in;
         sat_ff <= over;
      end
   end

   assign res = res_ff;
   assign sat = sat_ff;

endmodule

// ===== design/matrix_vector_transform.sv =====
// A transform transaction passes the input, product, pair-sum, total and result registers.
// Throughput: one transaction per cycle while rsp_tready is high; a coefficient load takes
// a slot, gives no result. Each stage has its own valid bit and ready, so bubbles close up
// behind a stalled output register; req_tready follows rsp_tready through the ready chain
// in the same cycle. Reset clears all valid bits and loads the identity matrix.
module matrix_vector_transform #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // coeff_row[1:0], coeff_col[3:2], coeff_value[35:4], in_x[67:36], in_y[99:68],
   // in_z[131:100], in_w[163:132], zero fill[167:164]
   input  logic [mvt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation[1:0]
   input  logic [mvt_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
   output logic [mvt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // saturated[0]
   output logic [0:0]                         rsp_tuser
);
   import mvt_pkg::*;

   localparam int VAL_LSB = 2 * IDX_W;
   localparam int VEC_LSB = VAL_LSB + COMP_W;
   localparam logic [COMP_W-1:0] ONE = COMP_W'(1) << FRACTION_BITS;

   // Input register
   logic                     v0_ff;
   op_type                   op0_ff;
   logic [IDX_W-1:0]         row0_ff;
   logic [IDX_W-1:0]         col0_ff;
   logic signed [COMP_W-1:0] value0_ff;
   logic signed [COMP_W-1:0] vec0_ff [VEC_N];
   logic signed [COMP_W-1:0] vec0_in [VEC_N];

   logic signed [COMP_W-1:0] coeff_ff [VEC_N][VEC_N];

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic pt1_ff, pt2_ff, pt3_ff, pt4_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;
   logic is_load, is_xfer, is_point;
   logic coeff_we;
   row_ctrl_type ctrl;

   logic [COMP_W-1:0] row_res [VEC_N];
   logic [VEC_N-1:0]  row_sat;

   // Ready ripples back from the output register.
   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign req_tready = rdy0;

   always_comb begin
      is_load  = 1'b0;
      is_xfer  = 1'b0;
      is_point = 1'b0;
      unique case (op0_ff)
         OP_LOAD:   is_load = 1'b1;
         OP_VECTOR: is_xfer = 1'b1;
         OP_POINT: begin
            is_xfer  = 1'b1;
            is_point = 1'b1;
         end
         default: ;
      endcase
   end

   // Loads update the matrix as they leave the input register, so any
   // transform ahead of them already has its products.
   assign coeff_we = v0_ff && is_load && rdy1;

   assign ctrl.ld1 = v0_ff && is_xfer && rdy1;
   assign ctrl.ld2 = v1_ff && rdy2;
   assign ctrl.ld3 = v2_ff && rdy3;
   assign ctrl.ld4 = v3_ff && rdy4;

   always_comb begin
      for (int k = 0; k < VEC_N - 1; k++) begin
         vec0_in[k] = req_tdata[VEC_LSB + k*COMP_W +: COMP_W];
      end
      if (op_type'(req_tuser) == OP_POINT) begin
         vec0_in[VEC_N-1] = ONE;
      end else begin
         vec0_in[VEC_N-1] = req_tdata[VEC_LSB + (VEC_N-1)*COMP_W +: COMP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_tvalid;
         if (rdy1) v1_ff <= v0_ff && is_xfer;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0 && req_tvalid) begin
         op0_ff    <= op_type'(req_tuser);
         row0_ff   <= req_tdata[IDX_W-1:0];
         col0_ff   <= req_tdata[2*IDX_W-1:IDX_W];
         value0_ff <= req_tdata[VAL_LSB +: COMP_W];
         vec0_ff   <= vec0_in;
      end
      if (ctrl.ld1) pt1_ff <= is_point;
      if (ctrl.ld2) pt2_ff <= pt1_ff;
      if (ctrl.ld3) pt3_ff <= pt2_ff;
      if (ctrl.ld4) pt4_ff <= pt3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < VEC_N; r++) begin
            for (int c = 0; c < VEC_N; c++) begin
               coeff_ff[r][c] <= (r == c) ? ONE : '0;
            end
         end
      end else if (coeff_we) begin
         coeff_ff[row0_ff][col0_ff] <= value0_ff;
      end
   end

   for (genvar r = 0; r < VEC_N; r++) begin : g_row
      mvt_row_dot #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_row (
         .clock (clock),
         .ctrl  (ctrl),
         .coeff (coeff_ff[r]),
         .vec   (vec0_ff),
         .res   (row_res[r]),
         .sat   (row_sat[r])
      );
   end

   // Point mode: drop w and its saturation.
   assign rsp_tvalid   = v4_ff;
   assign rsp_tdata    = {pt4_ff ? '0 : row_res[3], row_res[2], row_res[1], row_res[0]};
   assign rsp_tuser[0] = (|row_sat[2:0]) || (row_sat[3] && !pt4_ff);

endmodule

// ===== design/mvt_checker.sv =====
// Port-level checks of the matrix-vector transform unit, bound to the top level.
module mvt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mvt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                     rsp_tuser
);
   import mvt_pkg::*;

   logic req_xact;
   assign req_xact = req_tvalid && req_tready;

   // Reset empties the pipeline.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transaction changed");

   // With rsp_tready high every stage can move, so req must be ready.
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req_tready low while rsp_tready high");

   // With no new transaction and no back pressure for the depth of the pipeline, it is empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !$past(req_xact, 1) && !$past(req_xact, 2) && !$past(req_xact, 3) &&
      !$past(req_xact, 4) && !$past(req_xact, 5) &&
      $past(rsp_tready, 1) && $past(rsp_tready, 2) && $past(rsp_tready, 3) &&
      $past(rsp_tready, 4) && $past(rsp_tready, 5) |-> !rsp_tvalid)
      else $error("rsp transaction without a matching req transaction");

endmodule

bind matrix_vector_transform mvt_checker u_mvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/matrix_vector_transform_tb.sv =====
// Self-checking testbench of the 4x4 matrix-vector transform unit.
module matrix_vector_transform_tb;
   import mvt_pkg::*;

   localparam int FRAC_BITS     = 16;
   localparam int ACC_W         = 68;
   localparam int TOTAL_ITEMS   = 1850;
   localparam int PIPE_LATENCY  = 4;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int TIMEOUT_UNITS = 1_000_000;

   localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
   localparam logic [COMP_W-1:0] ONE_Q     = 32'h0001_0000;

   localparam logic signed [ACC_W-1:0] ACC_ONE = 68'sd1;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 68'sd2147483647;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -68'sd2147483648;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [COMP_W-1:0] coeff;
      logic [COMP_W-1:0] x;
      logic [COMP_W-1:0] y;
      logic [COMP_W-1:0] z;
      logic [COMP_W-1:0] w;
   } xform_req_type;

   typedef struct packed {
      logic [COMP_W-1:0] x;
      logic [COMP_W-1:0] y;
      logic [COMP_W-1:0] z;
      logic [COMP_W-1:0] w;
      logic              sat;
   } xform_rsp_type;

   typedef struct packed {
      xform_req_type rq;
      logic          typed;
      xform_rsp_type ex;
   } table_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = OP_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;

   logic [COMP_W-1:0] matrix_q [16];
   xform_rsp_type     expected_vertices [$];
   table_row_type     table_rows [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int vectors_sent  = 0;
   int points_sent   = 0;
   int loads_sent    = 0;
   int unused_sent   = 0;
   int results_seen  = 0;
   int saturated_seen = 0;

   matrix_vector_transform #(
      .FRACTION_BITS(FRAC_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // One row of the matrix times the vector: exact sum, round half up, saturate.
   function automatic logic [COMP_W:0] dot_row(input int r,
                                                input logic [VEC_N-1:0][COMP_W-1:0] vec);
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] coef;
      logic signed [ACC_W-1:0] comp;
      acc = '0;
      for (int k = 0; k < VEC_N; k++) begin
         coef = $signed(matrix_q[r * VEC_N + k]);
         comp = $signed(vec[k]);
         acc  = acc + coef * comp;
      end
      acc = acc + (ACC_ONE <<< (FRAC_BITS - 1));
      acc = acc >>> FRAC_BITS;
      if (acc > ACC_MAX) return {1'b1, SAT_MAX};
      if (acc < ACC_MIN) return {1'b1, SAT_MIN};
      return {1'b0, acc[COMP_W-1:0]};
   endfunction

   function automatic xform_rsp_type transform_vertex(input xform_req_type rq);
      logic [VEC_N-1:0][COMP_W-1:0] vec;
      logic [VEC_N-1:0][COMP_W-1:0] comp;
      logic [COMP_W:0]              row_out;
      xform_rsp_type                res;
      comp = '0;
      res  = '0;
      vec  = {(rq.op == OP_POINT) ? ONE_Q : rq.w, rq.z, rq.y, rq.x};
      // A point drops the fourth row entirely: w reads zero and cannot saturate.
      for (int r = 0; r < VEC_N; r++) begin
         if (r < 3 || rq.op == OP_VECTOR) begin
            row_out = dot_row(r, vec);
            comp[r] = row_out[COMP_W-1:0];
            res.sat = res.sat | row_out[COMP_W];
         end
      end
      res.x = comp[0];
      res.y = comp[1];
      res.z = comp[2];
      res.w = comp[3];
      return res;
   endfunction

   // Mostly moderate values, with extremes, tiny values and full-range words mixed in.
   function automatic logic [COMP_W-1:0] random_q16(input int moderate_bits);
      int                pick;
      logic [COMP_W-1:0] raw;
      logic [COMP_W-1:0] mod;
      pick = $urandom_range(99);
      raw  = $urandom;
      if (pick < 3) return SAT_MAX;
      if (pick < 6) return SAT_MIN;
      if (pick < 12) return raw;
      if (pick < 25) return {{(COMP_W - 4){raw[3]}}, raw[3:0]};
      mod = raw << (COMP_W - moderate_bits);
      return $signed(mod) >>> (COMP_W - moderate_bits);
   endfunction

   function automatic xform_req_type random_request();
      xform_req_type rq;
      int            sel;
      sel      = $urandom_range(99);
      rq.op    = (sel < 20) ? OP_LOAD : (sel < 23) ? OP_UNUSED :
                 (sel < 68) ? OP_VECTOR : OP_POINT;
      rq.row   = IDX_W'($urandom_range(3));
      rq.col   = IDX_W'($urandom_range(3));
      rq.coeff = random_q16(18);
      rq.x     = random_q16(22);
      rq.y     = random_q16(22);
      rq.z     = random_q16(22);
      rq.w     = random_q16(22);
      return rq;
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                          input logic [IDX_W-1:0] col, input logic [COMP_W-1:0] coeff,
                          input logic [COMP_W-1:0] x, input logic [COMP_W-1:0] y,
                          input logic [COMP_W-1:0] z, input logic [COMP_W-1:0] w,
                          input logic typed, input logic [COMP_W-1:0] ex_x,
                          input logic [COMP_W-1:0] ex_y, input logic [COMP_W-1:0] ex_z,
                          input logic [COMP_W-1:0] ex_w, input logic ex_sat);
      table_row_type tr;
      tr.rq    = '{op: op, row: row, col: col, coeff: coeff, x: x, y: y, z: z, w: w};
      tr.typed = typed;
      tr.ex    = '{x: ex_x, y: ex_y, z: ex_z, w: ex_w, sat: ex_sat};
      table_rows.push_back(tr);
   endtask

   // Entered and left at a falling edge; valid stays high between back-to-back items.
   task automatic send_item(input xform_req_type rq, input logic typed,
                            input xform_rsp_type ex);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.op;
      req_tdata  <= REQ_DATA_W'({rq.w, rq.z, rq.y, rq.x, rq.coeff, rq.col, rq.row});
      do @(posedge clock); while (!req_tready);
      if (rq.op == OP_LOAD) begin
         matrix_q[{rq.row, rq.col}] = rq.coeff;
         loads_sent++;
      end else if (rq.op == OP_UNUSED) begin
         unused_sent++;
      end else begin
         expected_vertices.push_back(typed ? ex : transform_vertex(rq));
         if (rq.op == OP_VECTOR) vectors_sent++;
         else points_sent++;
      end
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [COMP_W-1:0] want,
                              input logic [COMP_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      xform_rsp_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_vertices.size() == 0) begin
            $display("%0t: result with no transaction pending, expected none, actual %h/%b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            due = expected_vertices.pop_front();
            check_field("out_x", due.x, rsp_tdata[31:0]);
            check_field("out_y", due.y, rsp_tdata[63:32]);
            check_field("out_z", due.z, rsp_tdata[95:64]);
            check_field("out_w", due.w, rsp_tdata[127:96]);
            check_field("saturated", COMP_W'(due.sat), COMP_W'(rsp_tuser[0]));
            results_seen++;
            if (rsp_tuser[0]) saturated_seen++;
         end
      end
   end

   initial begin
      #TIMEOUT_UNITS;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int random_items;
      int drain_cycles;
      for (int i = 0; i < 16; i++) matrix_q[i] = (i % 5 == 0) ? ONE_Q : '0;

      // Identity after reset, full-scale components, point mode ignoring w.
      add_row(OP_VECTOR, 0, 0, 0, ONE_Q, 32'h0002_0000, 32'hFFFC_8000, ONE_Q,
              1, ONE_Q, 32'h0002_0000, 32'hFFFC_8000, ONE_Q, 0);
      add_row(OP_VECTOR, 0, 0, 0, SAT_MIN, SAT_MAX, 0, 32'hFFFF_FFFF,
              1, SAT_MIN, SAT_MAX, 0, 32'hFFFF_FFFF, 0);
      add_row(OP_POINT, 0, 0, 0, SAT_MAX, SAT_MIN, 32'h1234_5678, 32'hDEAD_BEEF,
              1, SAT_MAX, SAT_MIN, 32'h1234_5678, 0, 0);
      // The unused code must leave the matrix alone.
      add_row(OP_UNUSED, 3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
      add_row(OP_VECTOR, 0, 0, 0, 32'h1, 32'hFFFF_FFFF, 0, SAT_MIN,
              1, 32'h1, 32'hFFFF_FFFF, 0, SAT_MIN, 0);
      // Positive and negative overflow.
      add_row(OP_LOAD, 0, 0, SAT_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_VECTOR, 0, 0, 0, SAT_MAX, 0, 0, 0, 1, SAT_MAX, 0, 0, 0, 1);
      add_row(OP_VECTOR, 0, 0, 0, SAT_MIN, 0, 0, 0, 1, SAT_MIN, 0, 0, 0, 1);
      add_row(OP_LOAD, 3, 3, SAT_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_POINT, 0, 0, 0, 0, 0, 0, SAT_MAX, 1, 0, 0, 0, 0, 0);
      add_row(OP_VECTOR, 0, 0, 0, 0, 0, 0, SAT_MIN, 1, 0, 0, 0, SAT_MAX, 1);
      // Half-scale coefficient exposes rounding ties.
      add_row(OP_LOAD, 1, 1, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_VECTOR, 0, 0, 0, 0, 32'h1, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_VECTOR, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_VECTOR, 0, 0, 0, 0, 32'h3, 0, 0, 0, 0, 0, 0, 0, 0);
      // Four maximal products in one row overflow 64 bits.
      add_row(OP_LOAD, 0, 0, SAT_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 0, 1, SAT_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 0, 2, SAT_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 0, 3, SAT_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_VECTOR, 0, 0, 0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 0, 0, 0, 0, 0, 0);
      add_row(OP_POINT, 0, 0, 0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 2, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_VECTOR, 0, 0, 0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 0, 0, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 11;
      recv_idle_pct = 62;
      foreach (table_rows[i]) send_item(table_rows[i].rq, table_rows[i].typed, table_rows[i].ex);

      random_items = TOTAL_ITEMS - table_rows.size();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 62 : 0;
         recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 11 : 0;
         for (int i = 0; i < random_items / 3; i++) send_item(random_request(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      drain_cycles = 0;
      while (expected_vertices.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      // Keep clocking afterwards to catch stray results.
      repeat (3 * PIPE_LATENCY) @(posedge clock);
      if (expected_vertices.size() != 0) begin
         $display("%0t: results missing, expected %0d more, actual 0",
                  $time, expected_vertices.size());
         error_count++;
      end

      $display("Sent %0d vector and %0d point transforms, %0d coefficient loads, %0d unused codes",
               vectors_sent, points_sent, loads_sent, unused_sent);
      $display("Checked %0d results, %0d of them clipped", results_seen, saturated_seen);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
